// File: sv/sutd_pkg.sv
// ----------------------------------------------------------------------------
// sutd_pkg
// Constants, tables and helpers for the seconds to utc date converter.
// ----------------------------------------------------------------------------
package sutd_pkg;

  // divide by 86400: (x >> 7) / 675 through a reciprocal, exact for 25-bit x
  localparam logic [25:0] DayRecip    = 26'd50903317;
  localparam int          DayShift    = 35;
  localparam logic [16:0] SecsPerDay  = 17'd86400;

  // divide a day count by 1461, exact for 16-bit x
  localparam logic [16:0] QuadRecip   = 17'd91868;
  localparam int          QuadShift   = 27;
  localparam logic [10:0] DaysPerQuad = 11'd1461;

  // divide by 3600: (x >> 4) / 225, exact for 13-bit x
  localparam logic [13:0] HourRecip   = 14'd9321;
  localparam int          HourShift   = 21;
  localparam logic [11:0] SecsPerHour = 12'd3600;

  // divide by 60: (x >> 2) / 15, exact for 10-bit x
  localparam logic [10:0] MinRecip    = 11'd1093;
  localparam int          MinShift    = 14;
  localparam logic [5:0]  SecsPerMin  = 6'd60;

  localparam logic [7:0]  FirstYear    = 8'd70;
  localparam logic [2:0]  FirstWeekday = 3'd4;

  // start of each year inside a four-year interval, in days
  localparam logic [10:0] Year1Start = 11'd365;
  localparam logic [10:0] Year2Start = 11'd730;
  localparam logic [10:0] Year3Start = 11'd1096;

  localparam int NumMonths = 12;

  // entry m is the day of year of the last day of month m-1
  localparam logic signed [9:0] CumLeap [13] = '{
    -10'sd1, 10'sd30, 10'sd59, 10'sd90, 10'sd120, 10'sd151, 10'sd181,
    10'sd212, 10'sd243, 10'sd273, 10'sd304, 10'sd334, 10'sd365
  };
  localparam logic signed [9:0] CumCommon [13] = '{
    -10'sd1, 10'sd30, 10'sd58, 10'sd89, 10'sd119, 10'sd150, 10'sd180,
    10'sd211, 10'sd242, 10'sd272, 10'sd303, 10'sd333, 10'sd364
  };

  function automatic logic signed [9:0] month_last(input logic leap, input logic [3:0] idx);
    logic signed [9:0] val;
    if (idx > 4'd12) begin
      val = 10'sd0;
    end else if (leap) begin
      val = CumLeap[idx];
    end else begin
      val = CumCommon[idx];
    end
    return val;
  endfunction

  // x mod 7 by folding octal digits, since 8 = 1 mod 7
  function automatic logic [2:0] mod7(input logic [16:0] x);
    logic [17:0] xe;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    logic [3:0]  r;
    xe = {1'b0, x};
    s1 = 6'(xe[2:0]) + 6'(xe[5:3]) + 6'(xe[8:6]) + 6'(xe[11:9])
       + 6'(xe[14:12]) + 6'(xe[17:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    r  = (s3 >= 4'd7) ? s3 - 4'd7 : s3;
    return r[2:0];
  endfunction

endpackage

// File: sv/sutd_tod.sv
// ----------------------------------------------------------------------------
// sutd_tod
// Time-of-day pipeline: seconds of the day into hour, minute and second.
// Four register stages, no stall, outputs registered.
// ----------------------------------------------------------------------------
module sutd_tod (
  input  logic        clk,
  input  logic [16:0] sod,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);

  // stage a: hour estimate product
  logic [16:0] sod_a;
  logic [26:0] hour_prod_a;

  // stage b: hour and remainder within the hour
  logic [4:0]  hour_c;
  logic [16:0] hour_base;
  logic [16:0] rem_full;
  logic [4:0]  hour_b;
  logic [11:0] rem_b;

  // stage c: minute estimate product
  logic [4:0]  hour_c2;
  logic [11:0] rem_c;
  logic [20:0] min_prod_c;

  // stage d: minute and second
  logic [5:0]  minute_c;
  logic [11:0] min_base;
  logic [11:0] sec_full;

  assign hour_c    = hour_prod_a[sutd_pkg::HourShift +: 5];
  assign hour_base = hour_c * sutd_pkg::SecsPerHour;
  assign rem_full  = sod_a - hour_base;

  assign minute_c  = min_prod_c[sutd_pkg::MinShift +: 6];
  assign min_base  = minute_c * sutd_pkg::SecsPerMin;
  assign sec_full  = rem_c - min_base;

  always_ff @(posedge clk) begin
    sod_a       <= sod;
    hour_prod_a <= sod[16:4] * sutd_pkg::HourRecip;

    hour_b      <= hour_c;
    rem_b       <= rem_full[11:0];

    hour_c2     <= hour_b;
    rem_c       <= rem_b;
    min_prod_c  <= rem_b[11:2] * sutd_pkg::MinRecip;

    hour_of_day      <= hour_c2;
    minute_of_hour   <= minute_c;
    second_of_minute <= sec_full[5:0];
  end

endmodule

// File: sv/seconds_to_utc_date.sv
// ----------------------------------------------------------------------------
// seconds_to_utc_date
// Unsigned 32-bit seconds since 1970-01-01 00:00 UTC to a broken-down UTC date.
// ----------------------------------------------------------------------------
// Fully pipelined: one item may start in every cycle and busy is always low.
// The result of an item shows on the result ports with done high for one
// cycle, after the item has passed through the six register stages (day
// estimate, day split, four-year split, year split, month search, day of
// month). Results cannot be held off and must be taken when done is high.
// Every fourth year counts as leap, 2100 included, so dates from 2100-03-01 on
// come out one day late; the weekday is always right.
module seconds_to_utc_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [7:0]  years_since_1900,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute,
  output logic [2:0]  day_of_week,
  output logic [8:0]  day_of_year
);

  // valid bits, one per stage
  logic v1, v2, v3, v4, v5, v6;

  // stage 1
  logic [31:0] secs_s1;
  logic [50:0] day_prod_s1;

  // stage 2
  logic [15:0] days_c;
  logic [32:0] day_base;
  logic [31:0] sod_full;
  logic [15:0] days_s2;
  logic [16:0] sod_s2;
  logic [32:0] quad_prod_s2;

  // stage 3
  logic [5:0]  quads_c;
  logic [16:0] quad_base;
  logic [15:0] doq_full;
  logic [5:0]  quads_s3;
  logic [10:0] doq_s3;
  logic [2:0]  wday_s3;

  // stage 4
  logic [1:0]  yoff_c;
  logic [10:0] ystart_c;
  logic [10:0] yday_full;
  logic        leap_c;
  logic [7:0]  year_s4;
  logic [8:0]  yday_s4;
  logic        leap_s4;
  logic [2:0]  wday_s4;

  // stage 5
  logic [3:0]  month_c;
  logic [7:0]  year_s5;
  logic [8:0]  yday_s5;
  logic        leap_s5;
  logic [2:0]  wday_s5;
  logic [3:0]  month_s5;

  // stage 6
  logic signed [9:0] mday_full;

  assign busy = 1'b0;
  assign done = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 1: day count estimate
  always_ff @(posedge clk) begin
    secs_s1     <= epoch_seconds;
    day_prod_s1 <= epoch_seconds[31:7] * sutd_pkg::DayRecip;
  end

  // stage 2: day count and seconds of the day
  assign days_c   = day_prod_s1[sutd_pkg::DayShift +: 16];
  assign day_base = days_c * sutd_pkg::SecsPerDay;
  assign sod_full = secs_s1 - day_base[31:0];

  always_ff @(posedge clk) begin
    days_s2      <= days_c;
    sod_s2       <= sod_full[16:0];
    quad_prod_s2 <= days_c * sutd_pkg::QuadRecip;
  end

  // stage 3: four-year intervals and weekday
  assign quads_c   = quad_prod_s2[sutd_pkg::QuadShift +: 6];
  assign quad_base = quads_c * sutd_pkg::DaysPerQuad;
  assign doq_full  = days_s2 - quad_base[15:0];

  always_ff @(posedge clk) begin
    quads_s3 <= quads_c;
    doq_s3   <= doq_full[10:0];
    wday_s3  <= sutd_pkg::mod7(17'(days_s2) + 17'(sutd_pkg::FirstWeekday));
  end

  // stage 4: year within the interval, the third one is leap
  always_comb begin
    yoff_c   = 2'd0;
    ystart_c = 11'd0;
    leap_c   = 1'b0;
    if (doq_s3 >= sutd_pkg::Year3Start) begin
      yoff_c   = 2'd3;
      ystart_c = sutd_pkg::Year3Start;
    end else if (doq_s3 >= sutd_pkg::Year2Start) begin
      yoff_c   = 2'd2;
      ystart_c = sutd_pkg::Year2Start;
      leap_c   = 1'b1;
    end else if (doq_s3 >= sutd_pkg::Year1Start) begin
      yoff_c   = 2'd1;
      ystart_c = sutd_pkg::Year1Start;
    end
  end

  assign yday_full = doq_s3 - ystart_c;

  always_ff @(posedge clk) begin
    year_s4 <= sutd_pkg::FirstYear + {quads_s3, 2'b00} + 8'(yoff_c);
    yday_s4 <= yday_full[8:0];
    leap_s4 <= leap_c;
    wday_s4 <= wday_s3;
  end

  // stage 5: month is the number of month ends passed
  always_comb begin
    month_c = 4'd0;
    for (int m = 1; m < sutd_pkg::NumMonths; m++) begin
      if (sutd_pkg::month_last(leap_s4, 4'(m)) < $signed({1'b0, yday_s4})) begin
        month_c = month_c + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    year_s5  <= year_s4;
    yday_s5  <= yday_s4;
    leap_s5  <= leap_s4;
    wday_s5  <= wday_s4;
    month_s5 <= month_c;
  end

  // stage 6: day of month and output registers
  assign mday_full = $signed({1'b0, yday_s5}) - sutd_pkg::month_last(leap_s5, month_s5);

  always_ff @(posedge clk) begin
    years_since_1900 <= year_s5;
    month_index      <= month_s5;
    day_of_month     <= mday_full[4:0];
    day_of_week      <= wday_s5;
    day_of_year      <= yday_s5;
  end

  sutd_tod u_tod (
    .clk              (clk),
    .sod              (sod_s2),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

endmodule

// File: bench/seconds_to_utc_date_tb.sv
// ----------------------------------------------------------------------------
// seconds_to_utc_date_tb
// Self-checking bench for the seconds to utc date converter: directed corner
// timestamps, then random bursts aimed at day, year and four-year boundaries,
// each result compared field by field against an in-bench calendar model.
// ----------------------------------------------------------------------------
module seconds_to_utc_date_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DAY_SECS  = 86400;
  localparam int unsigned YEAR_SECS = 365 * DAY_SECS;
  localparam int unsigned LEAP_SECS = 366 * DAY_SECS;
  localparam int unsigned QUAD_SECS = 1461 * DAY_SECS;
  localparam int          NUM_RANDOM = 1400;
  localparam int          DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
    logic [8:0] yday;
  } utc_date_t;

  class date_scoreboard;
    utc_date_t expected_dates[$];
    int        errors;
    int        compared;

    function new();
      errors   = 0;
      compared = 0;
    endfunction

    function utc_date_t predict_date(logic [31:0] secs);
      int unsigned rest;
      int unsigned quads;
      int unsigned year;
      int unsigned yday;
      int unsigned mon;
      int unsigned hr;
      int unsigned mn;
      bit          leap;
      int          cum[13];
      int          leap_cum[13] = '{-1, 30, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
      int          common_cum[13] = '{-1, 30, 58, 89, 119, 150, 180, 211, 242, 272, 303, 333, 364};
      utc_date_t   d;
      leap  = 1'b0;
      quads = secs / QUAD_SECS;
      rest  = secs - quads * QUAD_SECS;
      year  = 70 + quads * 4;
      // third year of each four-year interval is the leap one
      if (rest >= YEAR_SECS) begin
        year++;
        rest -= YEAR_SECS;
        if (rest >= YEAR_SECS) begin
          year++;
          rest -= YEAR_SECS;
          if (rest >= LEAP_SECS) begin
            year++;
            rest -= LEAP_SECS;
          end else begin
            leap = 1'b1;
          end
        end
      end
      yday = rest / DAY_SECS;
      rest -= yday * DAY_SECS;
      if (leap) begin
        cum = leap_cum;
      end else begin
        cum = common_cum;
      end
      mon = 0;
      while (mon < 11 && cum[mon + 1] < int'(yday)) mon++;
      hr = rest / 3600;
      rest -= hr * 3600;
      mn = rest / 60;
      d.year   = year[7:0];
      d.month  = mon[3:0];
      d.mday   = 5'(int'(yday) - cum[mon]);
      d.hour   = hr[4:0];
      d.minute = mn[5:0];
      d.second = 6'(rest - mn * 60);
      d.wday   = 3'((secs / DAY_SECS + 4) % 7);
      d.yday   = yday[8:0];
      return d;
    endfunction

    function void note_input(logic [31:0] secs);
      expected_dates.push_back(predict_date(secs));
    endfunction

    function void field_check(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (got_val !== exp_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      end
    endfunction

    function void check_result(utc_date_t got);
      utc_date_t exp_d;
      if (expected_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      exp_d = expected_dates.pop_front();
      compared++;
      field_check("years_since_1900", 32'(exp_d.year),   32'(got.year));
      field_check("month_index",      32'(exp_d.month),  32'(got.month));
      field_check("day_of_month",     32'(exp_d.mday),   32'(got.mday));
      field_check("hour_of_day",      32'(exp_d.hour),   32'(got.hour));
      field_check("minute_of_hour",   32'(exp_d.minute), 32'(got.minute));
      field_check("second_of_minute", 32'(exp_d.second), 32'(got.second));
      field_check("day_of_week",      32'(exp_d.wday),   32'(got.wday));
      field_check("day_of_year",      32'(exp_d.yday),   32'(got.yday));
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] epoch_seconds;
  logic        done;
  logic [7:0]  years_since_1900;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;
  logic [2:0]  day_of_week;
  logic [8:0]  day_of_year;

  date_scoreboard sb;
  int             items_sent;

  seconds_to_utc_date DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .epoch_seconds    (epoch_seconds),
    .done             (done),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .day_of_week      (day_of_week),
    .day_of_year      (day_of_year)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // start stays high across a burst, so back-to-back items need no re-raise
  task automatic send_item(input logic [31:0] secs);
    start         <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [31:0] clip_secs(longint v);
    if (v < 0) return 32'd0;
    if (v > longint'(32'hFFFF_FFFF)) return $urandom;
    return v[31:0];
  endfunction

  function automatic logic [31:0] random_epoch();
    int     mode;
    longint day;
    longint off;
    int     k;
    int     year_start[4] = '{0, 365, 730, 1096};
    int     year_len[4] = '{365, 365, 366, 365};
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: begin
        return $urandom;
      end
      3: begin
        day = $urandom_range(0, 49710);
        case ($urandom_range(0, 3))
          0: off = 0;
          1: off = 1;
          2: off = DAY_SECS - 1;
          default: off = $urandom_range(0, DAY_SECS - 1);
        endcase
        return clip_secs(day * DAY_SECS + off);
      end
      4, 5: begin
        // straddle the start of a year
        k   = $urandom_range(0, 3);
        day = longint'($urandom_range(0, 34)) * 1461 + year_start[k];
        off = longint'($urandom_range(0, 7200)) - 3600;
        return clip_secs(day * DAY_SECS + off);
      end
      6, 7: begin
        // any day of a chosen year, mostly on the day's first or last second
        k   = $urandom_range(0, 3);
        day = longint'($urandom_range(0, 34)) * 1461 + year_start[k]
            + $urandom_range(0, year_len[k] - 1);
        case ($urandom_range(0, 2))
          0: off = 0;
          1: off = DAY_SECS - 1;
          default: off = $urandom_range(0, DAY_SECS - 1);
        endcase
        return clip_secs(day * DAY_SECS + off);
      end
      8: begin
        return $urandom_range(0, 200000000);
      end
      default: begin
        return 32'hFFFF_FFFF - $urandom_range(0, 100000000);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_input(epoch_seconds);
      if (done) begin
        sb.check_result('{years_since_1900, month_index, day_of_month, hour_of_day,
                          minute_of_hour, second_of_minute, day_of_week, day_of_year});
      end
    end
  end

  initial begin
    logic [31:0] directed[$];
    int          burst_len;
    int          sent_random;
    int          num_directed;
    sb            = new();
    items_sent    = 0;
    rst           = 1'b1;
    start         = 1'b0;
    epoch_seconds = 32'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd68083200,            // 1972-02-28
      32'd68169600,            // 1972-02-29, leap day
      32'd68256000,            // 1972-03-01
      32'd94694399,            // last second of leap 1972
      32'd94694400,            // first second of 1973
      32'd126230399, 32'd126230400,  // end of first four-year interval
      32'h7FFF_FFFF, 32'h8000_0000,
      32'd4107456000,          // 2100-02-28
      32'd4107542400,          // 2100-02-29, leap although not gregorian
      32'd4107628800,          // 2100-03-01, one day late from here on
      32'hAAAA_AAAA, 32'h5555_5555,
      32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    num_directed = directed.size();
    foreach (directed[i]) begin
      send_item(directed[i]);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 6));
    end

    sent_random = 0;
    while (sent_random < NUM_RANDOM) begin
      burst_len = $urandom_range(1, 24);
      repeat (burst_len) begin
        send_item(random_epoch());
        sent_random++;
      end
      // a quarter of the bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 7));
    end
    idle_for(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (done === 1'b1) sb.errors++;

    $display("converted %0d timestamps (%0d directed corners, rest random bursts)",
             items_sent, num_directed);
    $display("compared %0d dates field by field, %0d mismatches", sb.compared, sb.errors);
    if (sb.errors == 0) begin
      $display("seconds_to_utc_date_tb: clean");
    end else begin
      $display("seconds_to_utc_date_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d dates outstanding", sb.pending());
    $display("seconds_to_utc_date_tb: errors");
    $finish;
  end

endmodule

// File: files.f
sv/sutd_pkg.sv
sv/sutd_tod.sv
sv/seconds_to_utc_date.sv
bench/seconds_to_utc_date_tb.sv
